[design/apbp_pkg.sv]
// Shared types and constants for the ARGB pixel blend and plot block.
// Holds the request/result item structs, the register file struct and register indexes.
// No dependencies.
package apbp_pkg;

	// Configuration port geometry
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HORIZONTAL    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INVERTED      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DRAW_BUFFER   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BUFFER_BASE_0 = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BUFFER_BASE_1 = 3'd6;

	// Register reset values
	localparam logic [9:0] SCREEN_WIDTH_RST  = 10'd240;
	localparam logic [9:0] SCREEN_HEIGHT_RST = 10'd320;

	// Top row index of the landscape layout
	localparam logic [31:0] LANDSCAPE_ROW_TOP = 32'd239;

	localparam logic [7:0] FULL_ALPHA   = 8'hFF;
	localparam logic [6:0] PERCENT_FULL = 7'd100;

	typedef struct packed {
		logic        horizontal;
		logic        inverted;
		logic [9:0]  screen_width;
		logic [9:0]  screen_height;
		logic        draw_buffer;
		logic [31:0] buffer_base_0;
		logic [31:0] buffer_base_1;
	} cfg_t;

	typedef struct packed {
		logic [9:0]  pos_x;
		logic [9:0]  pos_y;
		logic [31:0] src_color;
		logic        to_grey;
		logic [6:0]  transparency;
		logic [31:0] old_pixel;
	} pixel_req_t;

	typedef struct packed {
		logic        write_enable;
		logic [31:0] pixel_address;
		logic [31:0] new_pixel;
	} pixel_res_t;

	// Color path result, one stage ahead of the output register
	typedef struct packed {
		logic        write_enable;
		logic [31:0] new_pixel;
	} blend_res_t;

endpackage

[design/apbp_cfg_regs.sv]
// Configuration register file of the ARGB pixel blend and plot block.
// Plain write port, no read-back. Depends on apbp_pkg.
module apbp_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [apbp_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  logic [apbp_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output apbp_pkg::cfg_t                 cfg
);

	apbp_pkg::cfg_t cfg_q;

	// Write the addressed register, drop writes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.horizontal    <= 1'b0;
			cfg_q.inverted      <= 1'b0;
			cfg_q.screen_width  <= apbp_pkg::SCREEN_WIDTH_RST;
			cfg_q.screen_height <= apbp_pkg::SCREEN_HEIGHT_RST;
			cfg_q.draw_buffer   <= 1'b0;
			cfg_q.buffer_base_0 <= '0;
			cfg_q.buffer_base_1 <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				apbp_pkg::REG_HORIZONTAL:    cfg_q.horizontal    <= cfg_wdata[0];
				apbp_pkg::REG_INVERTED:      cfg_q.inverted      <= cfg_wdata[0];
				apbp_pkg::REG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_wdata[9:0];
				apbp_pkg::REG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_wdata[9:0];
				apbp_pkg::REG_DRAW_BUFFER:   cfg_q.draw_buffer   <= cfg_wdata[0];
				apbp_pkg::REG_BUFFER_BASE_0: cfg_q.buffer_base_0 <= cfg_wdata;
				apbp_pkg::REG_BUFFER_BASE_1: cfg_q.buffer_base_1 <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[design/apbp_addr.sv]
// Address path: coordinate mirroring, layout multiply and base add over three stages.
// Depends on apbp_pkg for the register struct and the landscape row constant.
module apbp_addr #(
	parameter int COORD_BITS = 10
) (
	input  logic           clk,
	input  apbp_pkg::cfg_t cfg,
	input  logic [9:0]     pos_x,
	input  logic [9:0]     pos_y,
	output logic [31:0]    addr_s3
);

	localparam int PROD_W = COORD_BITS + 10;

	logic [COORD_BITS-1:0] x_c, y_c;
	logic [COORD_BITS-1:0] x_s1, y_s1;
	logic [31:0]           base_s1;
	logic [COORD_BITS-1:0] mul_a;
	logic [9:0]            mul_b;
	logic [PROD_W-1:0]     prod_c;
	logic [31:0]           off_c;
	logic [PROD_W-1:0]     prod_s2;
	logic [31:0]           part_s2;

	// Stage 1: wrap coordinates, mirror them, pick the buffer base
	always_comb begin
		x_c = COORD_BITS'(pos_x);
		y_c = COORD_BITS'(pos_y);
		if (cfg.inverted) begin
			x_c = COORD_BITS'(cfg.screen_width) - x_c;
			y_c = COORD_BITS'(cfg.screen_height) - y_c;
		end
	end

	always_ff @(posedge clk) begin
		x_s1    <= x_c;
		y_s1    <= y_c;
		base_s1 <= cfg.draw_buffer ? cfg.buffer_base_1 : cfg.buffer_base_0;
	end

	// Stage 2: row/column product and the base plus in-row offset
	always_comb begin
		mul_a  = cfg.horizontal ? x_s1 : y_s1;
		mul_b  = cfg.horizontal ? cfg.screen_height : cfg.screen_width;
		prod_c = PROD_W'(mul_a) * PROD_W'(mul_b);
		off_c  = cfg.horizontal ? (apbp_pkg::LANDSCAPE_ROW_TOP - 32'(y_s1)) : 32'(x_s1);
	end

	always_ff @(posedge clk) begin
		prod_s2 <= prod_c;
		part_s2 <= base_s1 + {off_c[29:0], 2'b00};
	end

	// Stage 3: add the scaled product, byte address wraps at 32 bits
	always_ff @(posedge clk) begin
		addr_s3 <= part_s2 + 32'({prod_s2, 2'b00});
	end

endmodule

[design/apbp_blend.sv]
// Color path: grey average, alpha scaling and per-channel blend over three stages,
// with the divide by 255 after the last register. Depends on apbp_pkg.
module apbp_blend (
	input  logic                 clk,
	input  logic [31:0]          src_color,
	input  logic                 to_grey,
	input  logic [6:0]           transparency,
	input  logic [31:0]          old_pixel,
	output apbp_pkg::blend_res_t blend
);

	// Reciprocals: floor(v/3) for v<=765, floor(v/100) for v<=25500,
	// floor(v/255) for v<=65025; each error stays below the smallest fraction
	localparam logic [19:0] RECIP_3   = 20'd683;
	localparam logic [29:0] RECIP_100 = 30'd20972;
	localparam logic [32:0] RECIP_255 = 33'd65794;

	logic [6:0]  pct_c;
	logic [9:0]  sum_s1;
	logic [14:0] aprod_s1;
	logic [23:0] rgb_s1;
	logic        grey_s1;
	logic [23:0] old_s1;

	logic [19:0] avg_prod;
	logic [29:0] alpha_prod;
	logic [7:0]  avg_c;
	logic [7:0]  alpha_s2;
	logic [23:0] rgb_s2;
	logic [23:0] old_s2;

	logic [7:0]  inv_alpha;
	logic [15:0] mix_c [3];
	logic [15:0] mix_s3 [3];
	logic        nz_s3;

	logic [32:0] quo_prod [3];
	logic [7:0]  quo [3];

	// Stage 1: channel sum and alpha times saturated percent
	always_comb begin
		pct_c = (transparency > apbp_pkg::PERCENT_FULL) ? apbp_pkg::PERCENT_FULL : transparency;
	end

	always_ff @(posedge clk) begin
		sum_s1   <= 10'(src_color[23:16]) + 10'(src_color[15:8]) + 10'(src_color[7:0]);
		aprod_s1 <= 15'(src_color[31:24]) * 15'(pct_c);
		rgb_s1   <= src_color[23:0];
		grey_s1  <= to_grey;
		old_s1   <= old_pixel[23:0];
	end

	// Stage 2: divide sum by three and product by one hundred
	always_comb begin
		avg_prod   = 20'(sum_s1) * RECIP_3;
		alpha_prod = 30'(aprod_s1) * RECIP_100;
		avg_c      = avg_prod[18:11];
	end

	always_ff @(posedge clk) begin
		alpha_s2 <= alpha_prod[28:21];
		rgb_s2   <= grey_s1 ? {avg_c, avg_c, avg_c} : rgb_s1;
		old_s2   <= old_s1;
	end

	// Stage 3: weighted sum per channel
	always_comb begin
		inv_alpha = apbp_pkg::FULL_ALPHA - alpha_s2;
		for (int i = 0; i < 3; i++) begin
			mix_c[i] = 16'(old_s2[8*i +: 8]) * 16'(inv_alpha)
				+ 16'(rgb_s2[8*i +: 8]) * 16'(alpha_s2);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			mix_s3[i] <= mix_c[i];
		end
		nz_s3 <= (alpha_s2 != 8'd0);
	end

	// Divide by 255; a transparent item writes nothing and carries a zero word
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			quo_prod[i] = 33'(mix_s3[i]) * RECIP_255;
			quo[i]      = quo_prod[i][31:24];
		end
		blend.write_enable = nz_s3;
		blend.new_pixel    = nz_s3 ? {apbp_pkg::FULL_ALPHA, quo[2], quo[1], quo[0]} : 32'd0;
	end

endmodule

[design/argb_pixel_blend_plot_top.sv]
// An accepted item (start high, busy low) strobes done after the s1-s3 and output registers.
// Throughput: one item per cycle; busy stays low, the pipeline never stalls.
// Stage depth is set by the blend multiplies and the reciprocal divides.
// Results show on result for one cycle with done; the receiver cannot hold them off.
// Reset clears the valid bits and the configuration registers; payload registers are not reset.
// Depends on apbp_pkg, apbp_cfg_regs, apbp_addr and apbp_blend.
module argb_pixel_blend_plot_top #(
	parameter int COORD_BITS = 10
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  apbp_pkg::pixel_req_t           req,
	output logic                           done,
	output apbp_pkg::pixel_res_t           result,
	input  logic                           cfg_we,
	input  logic [apbp_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  logic [apbp_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	apbp_pkg::cfg_t       cfg;
	apbp_pkg::blend_res_t blend;
	logic [31:0]          addr_s3;
	logic                 accept;
	logic                 valid_s1, valid_s2, valid_s3, valid_s4;
	apbp_pkg::pixel_res_t result_s4;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	apbp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	apbp_addr #(
		.COORD_BITS (COORD_BITS)
	) u_addr (
		.clk     (clk),
		.cfg     (cfg),
		.pos_x   (req.pos_x),
		.pos_y   (req.pos_y),
		.addr_s3 (addr_s3)
	);

	apbp_blend u_blend (
		.clk          (clk),
		.src_color    (req.src_color),
		.to_grey      (req.to_grey),
		.transparency (req.transparency),
		.old_pixel    (req.old_pixel),
		.blend        (blend)
	);

	// Advance the valid bits alongside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// Output register: join address and color paths
	always_ff @(posedge clk) begin
		result_s4.write_enable  <= blend.write_enable;
		result_s4.pixel_address <= addr_s3;
		result_s4.new_pixel     <= blend.new_pixel;
	end

	assign done   = valid_s4;
	assign result = result_s4;

`ifndef SYNTH
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##4 done)
		else $error("accepted item did not produce a result after four cycles");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 4))
		else $error("result without a matching accepted item");

	a_skip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.write_enable) |-> (result.new_pixel == 32'd0))
		else $error("skipped write carries a nonzero pixel");

	a_opaque_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.write_enable) |-> (result.new_pixel[31:24] == apbp_pkg::FULL_ALPHA))
		else $error("written pixel alpha byte is not full");
`endif

endmodule
